[design/czn_pkg.sv]
`default_nettype none
package czn_pkg;

  localparam int unsigned COORD_FRAC_DEF = 16;
  localparam int unsigned CELL_W         = 32;
  localparam int unsigned PX_FRAC        = 24;
  localparam int unsigned PX_W           = CELL_W + PX_FRAC;
  localparam int unsigned OFF_W          = 24;
  localparam int unsigned DX_W           = 26;
  localparam int unsigned SQ_W           = 50;
  localparam int unsigned D2_W           = 51;
  localparam int unsigned RAD_W          = 52;
  localparam int unsigned ROOT_W         = RAD_W / 2;
  localparam int unsigned SQ_STG         = ROOT_W / 2;
  localparam int unsigned HASH_LAT       = 7;
  localparam int unsigned NCELL          = 9;
  localparam int unsigned EDGE_W         = 17;
  localparam int unsigned CFG_IDX_W      = 8;

  localparam logic [CELL_W-1:0] MIN_SCALE   = 32'd66;
  localparam logic [CELL_W-1:0] SCALE_RESET = 32'd65536;
  localparam logic [63:0]       SEED_RESET  = 64'd0;

  localparam logic [63:0] MIX_K    = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] FMIX_C1  = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_C2  = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [31:0] HX_MUL   = 32'd73856093;
  localparam logic [31:0] HY_MUL   = 32'd19349663;
  localparam logic [63:0] SALT_X   = 64'h11;
  localparam logic [63:0] SALT_Y   = 64'h37;
  localparam logic [63:0] SALT_V   = 64'h5b;

  localparam logic [OFF_W-1:0]  OFF_MUL  = 24'd13421773;
  localparam logic [OFF_W-1:0]  OFF_BIAS = 24'd1677722;
  localparam logic [21:0]       DIV5_MUL = 22'd3355443;
  localparam logic [EDGE_W-1:0] EDGE_MAX = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED  = 8'd0,
    CFG_SCALE = 8'd1
  } cfg_reg_e;

  // One combine step of the cell hash.
  function automatic logic [63:0] mix_in(logic [63:0] s, logic [63:0] v);
    return s ^ (v + MIX_K + (s << 6) + (s >> 2));
  endfunction

endpackage
`default_nettype wire

[design/czn_div.sv]
`default_nettype none
module czn_div import czn_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [CELL_W-1:0] coord_i,
  input  logic [CELL_W-1:0] scale_i,
  output logic              valid_o,
  output logic [PX_W-1:0]   cell_o
);

  localparam int unsigned SHIFT = PX_FRAC + 16 - COORD_FRAC_BITS;
  localparam int unsigned NUM_W = CELL_W + SHIFT;
  localparam int unsigned NSTG  = (NUM_W + 1) / 2;
  localparam int unsigned NPAD  = 2 * NSTG;

  logic              v_q   [NSTG+1];
  logic              neg_q [NSTG+1];
  logic [NPAD-1:0]   num_q [NSTG+1];
  logic [NPAD-1:0]   quo_q [NSTG+1];
  logic [CELL_W-1:0] rem_q [NSTG+1];
  logic [CELL_W-1:0] mag;
  logic [63:0]       q64;
  logic              vo_q;
  logic [PX_W-1:0]   cell_q;

  // Split sign and magnitude, align the magnitude to the Q.24 grid.
  assign mag = coord_i[CELL_W-1] ? (~coord_i + 32'd1) : coord_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= coord_i[CELL_W-1];
    num_q[0] <= NPAD'(mag) << SHIFT;
    quo_q[0] <= '0;
    rem_q[0] <= '0;
  end

  // Two restoring quotient bits per stage.
  for (genvar s = 1; s <= NSTG; s++) begin : g_stg
    logic [NPAD-1:0]   num_d;
    logic [NPAD-1:0]   quo_d;
    logic [CELL_W-1:0] rem_d;

    always_comb begin
      logic [CELL_W:0] t;
      num_d = num_q[s-1];
      quo_d = quo_q[s-1];
      rem_d = rem_q[s-1];
      t     = '0;
      for (int k = 0; k < 2; k++) begin
        t     = {rem_d, num_d[NPAD-1]};
        num_d = num_d << 1;
        if (t >= {1'b0, scale_i}) begin
          rem_d = CELL_W'(t - {1'b0, scale_i});
          quo_d = {quo_d[NPAD-2:0], 1'b1};
        end else begin
          rem_d = t[CELL_W-1:0];
          quo_d = {quo_d[NPAD-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[s] <= neg_q[s-1];
      num_q[s] <= num_d;
      quo_q[s] <= quo_d;
      rem_q[s] <= rem_d;
    end
  end

  // Negative inputs round toward minus infinity: -(q + (rem != 0)).
  assign q64 = 64'(quo_q[NSTG]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (neg_q[NSTG]) begin
      cell_q <= PX_W'(~q64 + 64'(rem_q[NSTG] == '0));
    end else begin
      cell_q <= PX_W'(q64);
    end
  end

  assign valid_o = vo_q;
  assign cell_o  = cell_q;

endmodule
`default_nettype wire

[design/czn_hash.sv]
`default_nettype none
module czn_hash import czn_pkg::*; (
  input  logic              clk_i,
  input  logic [63:0]       seed_i,
  input  logic [CELL_W-1:0] sx_i,
  input  logic [CELL_W-1:0] sy_i,
  output logic [CELL_W-1:0] hash_o
);

  logic [31:0] mx_q, my_q, my2_q;
  logic [63:0] h1_q, h3_q, m1_q;
  logic [63:0] h2, m1, m2;
  logic [63:0] pa1_q, pa2_q;
  logic [31:0] pb1_q, pc1_q, pb2_q, pc2_q;
  logic [31:0] hash_q;

  assign h2 = mix_in(h1_q, {{32{my2_q[31]}}, my2_q});
  assign m1 = pa1_q + {pb1_q + pc1_q, 32'd0};
  assign m2 = pa2_q + {pb2_q + pc2_q, 32'd0};

  // Wrapping index products, two combine steps, then two finalizer rounds
  // with each 64-bit product split into 32-bit partial products.
  always_ff @(posedge clk_i) begin
    mx_q   <= sx_i * HX_MUL;
    my_q   <= sy_i * HY_MUL;
    h1_q   <= mix_in(seed_i, {{32{mx_q[31]}}, mx_q});
    my2_q  <= my_q;
    h3_q   <= h2 ^ (h2 >> 33);
    pa1_q  <= 64'(h3_q[31:0]) * 64'(FMIX_C1[31:0]);
    pb1_q  <= h3_q[63:32] * FMIX_C1[31:0];
    pc1_q  <= h3_q[31:0] * FMIX_C1[63:32];
    m1_q   <= m1 ^ (m1 >> 33);
    pa2_q  <= 64'(m1_q[31:0]) * 64'(FMIX_C2[31:0]);
    pb2_q  <= m1_q[63:32] * FMIX_C2[31:0];
    pc2_q  <= m1_q[31:0] * FMIX_C2[63:32];
    hash_q <= m2[31:0] ^ m2[64-1:33];
  end

  assign hash_o = hash_q;

endmodule
`default_nettype wire

[design/czn_isqrt.sv]
`default_nettype none
module czn_isqrt import czn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic              v_q    [SQ_STG+1];
  logic [RAD_W-1:0]  rad_q  [SQ_STG+1];
  logic [REM_W-1:0]  rem_q  [SQ_STG+1];
  logic [ROOT_W-1:0] root_q [SQ_STG+1];

  // Two root bits per stage, radicand consumed two bits at a time.
  for (genvar s = 1; s <= SQ_STG; s++) begin : g_stg
    logic [RAD_W-1:0]  rad_d, rad_p;
    logic [REM_W-1:0]  rem_d, rem_p;
    logic [ROOT_W-1:0] root_d, root_p;
    logic              v_p;

    if (s == 1) begin : g_head
      assign v_p    = valid_i;
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_body
      assign v_p    = v_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
    end

    always_comb begin
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      rad_d  = rad_p;
      rem_d  = rem_p;
      root_d = root_p;
      t      = '0;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
        t     = {rem_d, rad_d[RAD_W-1 -: 2]};
        rad_d = rad_d << 2;
        trial = (REM_W+2)'({root_d, 2'b01});
        if (t >= trial) begin
          rem_d  = REM_W'(t - trial);
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(t);
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
    end
  end

  assign v_q[0]    = 1'b0;
  assign rad_q[0]  = '0;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  assign valid_o = v_q[SQ_STG];
  assign root_o  = root_q[SQ_STG];

endmodule
`default_nettype wire

[design/cellular_zone_noise.sv]
// Cellular (Worley F1/F2) noise, one sample per clock. A start pulse with
// coord_x_i/coord_y_i (signed, COORD_FRAC_BITS fraction bits) launches one
// word; busy_o is never raised, so a new word may enter on every cycle. Each
// word yields exactly one result, shown for one cycle under result_valid_o,
// in input order; the receiver cannot stall it and must take it then. Each
// word passes through the two coordinate dividers (two quotient bits per
// stage plus input and output registers), the neighbor index step, the 27
// cell hashes, distance and F1/F2 selection, the two square roots and the
// edge scaling, in that order. noise_seed and zone_scale are written
// through the cfg port (always ready) and must only change while no sample
// is in flight. zone_scale below 66 is treated as 66. zone_value_o is the
// raw 32-bit hash of the nearest site; edge_blend_o is clamp((sqrt F2 -
// sqrt F1) * 0.8, 0, 1) in Q1.16.
`default_nettype none
module cellular_zone_noise import czn_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [CELL_W-1:0] coord_x_i,
  input  logic signed [CELL_W-1:0] coord_y_i,
  output logic                     result_valid_o,
  output logic [CELL_W-1:0]        zone_value_o,
  output logic [EDGE_W-1:0]        edge_blend_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [63:0]              cfg_data_i
);

  // ---------------------------------------------------------------- config
  logic [63:0]       seed_q;
  logic [CELL_W-1:0] scale_q;
  logic [CELL_W-1:0] scale_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEED:  seed_q  <= cfg_data_i;
        CFG_SCALE: scale_q <= cfg_data_i[CELL_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign scale_eff   = (scale_q < MIN_SCALE) ? MIN_SCALE : scale_q;

  // ------------------------------------------------- cell-space conversion
  logic            dvx, dvy;
  logic [PX_W-1:0] px, py;

  czn_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_x (
    .clk_i, .rst_ni, .valid_i(start_i), .coord_i(coord_x_i),
    .scale_i(scale_eff), .valid_o(dvx), .cell_o(px)
  );

  czn_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_y (
    .clk_i, .rst_ni, .valid_i(start_i), .coord_i(coord_y_i),
    .scale_i(scale_eff), .valid_o(dvy), .cell_o(py)
  );

  // Neighbor cell indexes for offsets -1, 0, +1; fractions ride along.
  logic              v_c_q;
  logic [CELL_W-1:0] sx_q [3];
  logic [CELL_W-1:0] sy_q [3];
  logic [OFF_W-1:0]  fx_c_q, fy_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0;
    end else begin
      v_c_q <= dvx & dvy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sx_q[k] <= px[PX_W-1:PX_FRAC] + CELL_W'(k) - 32'd1;
      sy_q[k] <= py[PX_W-1:PX_FRAC] + CELL_W'(k) - 32'd1;
    end
    fx_c_q <= px[PX_FRAC-1:0];
    fy_c_q <= py[PX_FRAC-1:0];
  end

  // ------------------------------------------------------------ cell hashes
  logic [CELL_W-1:0] hx [NCELL];
  logic [CELL_W-1:0] hy [NCELL];
  logic [CELL_W-1:0] hv [NCELL];

  // Cell i scans rows of y outermost: i = 3 * (oy + 1) + (ox + 1).
  for (genvar i = 0; i < NCELL; i++) begin : g_hash
    czn_hash u_hx (.clk_i, .seed_i(seed_q ^ SALT_X), .sx_i(sx_q[i % 3]),
                   .sy_i(sy_q[i / 3]), .hash_o(hx[i]));
    czn_hash u_hy (.clk_i, .seed_i(seed_q ^ SALT_Y), .sx_i(sx_q[i % 3]),
                   .sy_i(sy_q[i / 3]), .hash_o(hy[i]));
    czn_hash u_hv (.clk_i, .seed_i(seed_q ^ SALT_V), .sx_i(sx_q[i % 3]),
                   .sy_i(sy_q[i / 3]), .hash_o(hv[i]));
  end

  // Carry valid and fractions alongside the hash pipeline.
  logic             v_h_q  [HASH_LAT];
  logic [OFF_W-1:0] fx_h_q [HASH_LAT];
  logic [OFF_W-1:0] fy_h_q [HASH_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HASH_LAT; k++) v_h_q[k] <= 1'b0;
    end else begin
      v_h_q[0] <= v_c_q;
      for (int k = 1; k < HASH_LAT; k++) v_h_q[k] <= v_h_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fx_h_q[0] <= fx_c_q;
    fy_h_q[0] <= fy_c_q;
    for (int k = 1; k < HASH_LAT; k++) begin
      fx_h_q[k] <= fx_h_q[k-1];
      fy_h_q[k] <= fy_h_q[k-1];
    end
  end

  // -------------------------------------------------------- site distances
  // Stage O: site offset 0.1 + 0.8 * h / 2^32 in Q0.24.
  // Stage D: signed distance to the site. Stage Q: squares. Stage A: sum.
  logic                    v_o_q, v_d_q, v_s_q, v_a_q;
  logic [OFF_W-1:0]        fx_o_q, fy_o_q;
  logic [OFF_W-1:0]        offx_q [NCELL];
  logic [OFF_W-1:0]        offy_q [NCELL];
  logic signed [DX_W-1:0]  dx_q   [NCELL];
  logic signed [DX_W-1:0]  dy_q   [NCELL];
  logic [SQ_W-1:0]         sqx_q  [NCELL];
  logic [SQ_W-1:0]         sqy_q  [NCELL];
  logic [D2_W-1:0]         d2_a_q [NCELL];
  logic [CELL_W-1:0]       val_o_q [NCELL];
  logic [CELL_W-1:0]       val_d_q [NCELL];
  logic [CELL_W-1:0]       val_s_q [NCELL];
  logic [CELL_W-1:0]       val_a_q [NCELL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_o_q <= 1'b0;
      v_d_q <= 1'b0;
      v_s_q <= 1'b0;
      v_a_q <= 1'b0;
    end else begin
      v_o_q <= v_h_q[HASH_LAT-1];
      v_d_q <= v_o_q;
      v_s_q <= v_d_q;
      v_a_q <= v_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_o_q <= fx_h_q[HASH_LAT-1];
    fy_o_q <= fy_h_q[HASH_LAT-1];
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_dist
    localparam logic signed [DX_W-1:0] OXT =
      (i % 3 == 0) ? 26'sd16777216 : ((i % 3 == 2) ? -26'sd16777216 : 26'sd0);
    localparam logic signed [DX_W-1:0] OYT =
      (i / 3 == 0) ? 26'sd16777216 : ((i / 3 == 2) ? -26'sd16777216 : 26'sd0);

    logic [55:0]                 prx, pry;
    logic signed [2*DX_W-1:0]    px2, py2;

    assign prx = 56'(hx[i]) * 56'(OFF_MUL);
    assign pry = 56'(hy[i]) * 56'(OFF_MUL);
    assign px2 = dx_q[i] * dx_q[i];
    assign py2 = dy_q[i] * dy_q[i];

    always_ff @(posedge clk_i) begin
      offx_q[i]  <= prx[55:32] + OFF_BIAS;
      offy_q[i]  <= pry[55:32] + OFF_BIAS;
      val_o_q[i] <= hv[i];
      dx_q[i]    <= $signed({2'b00, fx_o_q}) + OXT - $signed({2'b00, offx_q[i]});
      dy_q[i]    <= $signed({2'b00, fy_o_q}) + OYT - $signed({2'b00, offy_q[i]});
      val_d_q[i] <= val_o_q[i];
      sqx_q[i]   <= px2[SQ_W-1:0];
      sqy_q[i]   <= py2[SQ_W-1:0];
      val_s_q[i] <= val_d_q[i];
      d2_a_q[i]  <= D2_W'(sqx_q[i]) + D2_W'(sqy_q[i]);
      val_a_q[i] <= val_s_q[i];
    end
  end

  // ---------------------------------------------------- F1 / F2 selection
  // Three cells per stage in scan order; strict less-than keeps the first
  // of equal distances as nearest.
  logic              sv_q    [3];
  logic [D2_W-1:0]   best_q  [3];
  logic [D2_W-1:0]   sec_q   [3];
  logic [CELL_W-1:0] bval_q  [3];
  logic [D2_W-1:0]   sd2_q   [3][NCELL];

  // Delay the value hashes with the distances so each stage sees its word.
  logic [CELL_W-1:0] val_sel_q [2][NCELL];

  always_ff @(posedge clk_i) begin
    val_sel_q[0] <= val_a_q;
    val_sel_q[1] <= val_sel_q[0];
  end

  for (genvar k = 0; k < 3; k++) begin : g_sel
    logic              v_p;
    logic [D2_W-1:0]   best_p, sec_p;
    logic [CELL_W-1:0] bval_p;
    logic [D2_W-1:0]   d2_p  [NCELL];
    logic [CELL_W-1:0] val_p [NCELL];
    logic [D2_W-1:0]   best_d, sec_d;
    logic [CELL_W-1:0] bval_d;

    if (k == 0) begin : g_head
      assign v_p    = v_a_q;
      assign best_p = '1;
      assign sec_p  = '1;
      assign bval_p = '0;
      assign d2_p   = d2_a_q;
      assign val_p  = val_a_q;
    end else begin : g_body
      assign v_p    = sv_q[k-1];
      assign best_p = best_q[k-1];
      assign sec_p  = sec_q[k-1];
      assign bval_p = bval_q[k-1];
      assign d2_p   = sd2_q[k-1];
      assign val_p  = val_sel_q[k-1];
    end

    always_comb begin
      best_d = best_p;
      sec_d  = sec_p;
      bval_d = bval_p;
      for (int j = 3 * k; j < 3 * k + 3; j++) begin
        if (d2_p[j] < best_d) begin
          sec_d  = best_d;
          best_d = d2_p[j];
          bval_d = val_p[j];
        end else if (d2_p[j] < sec_d) begin
          sec_d = d2_p[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else begin
        sv_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      best_q[k] <= best_d;
      sec_q[k]  <= sec_d;
      bval_q[k] <= bval_d;
      sd2_q[k]  <= d2_p;
    end
  end

  // ----------------------------------------------------------- square roots
  logic              rv1, rv2;
  logic [ROOT_W-1:0] root1, root2;
  logic [CELL_W-1:0] bval_dl_q [SQ_STG];

  czn_isqrt u_sqrt_f1 (
    .clk_i, .rst_ni, .valid_i(sv_q[2]), .rad_i(RAD_W'(best_q[2])),
    .valid_o(rv1), .root_o(root1)
  );

  czn_isqrt u_sqrt_f2 (
    .clk_i, .rst_ni, .valid_i(sv_q[2]), .rad_i(RAD_W'(sec_q[2])),
    .valid_o(rv2), .root_o(root2)
  );

  always_ff @(posedge clk_i) begin
    bval_dl_q[0] <= bval_q[2];
    for (int k = 1; k < SQ_STG; k++) bval_dl_q[k] <= bval_dl_q[k-1];
  end

  // ------------------------------------------------------------ edge blend
  // floor(diff / 320) = floor((diff >> 6) / 5); the reciprocal product is
  // low by at most one, fixed by one remainder compare.
  logic              v_b_q, v_r_q;
  logic [19:0]       x_q;
  logic [17:0]       q0_q;
  logic [CELL_W-1:0] val_b_q, zone_q;
  logic [EDGE_W-1:0] edge_q;
  logic [ROOT_W-1:0] rdiff;
  logic [41:0]       qprod;
  logic [19:0]       rem5;
  logic [17:0]       q1;

  assign rdiff = root2 - root1;
  assign qprod = {22'd0, rdiff[ROOT_W-1:6]} * {20'd0, DIV5_MUL};
  assign rem5  = x_q - ({q0_q, 2'b00} + {2'b00, q0_q});
  assign q1    = q0_q + 18'(rem5 >= 20'd5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
      v_r_q <= 1'b0;
    end else begin
      v_b_q <= rv1 & rv2;
      v_r_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= rdiff[ROOT_W-1:6];
    q0_q    <= qprod[41:24];
    val_b_q <= bval_dl_q[SQ_STG-1];
    zone_q  <= val_b_q;
    edge_q  <= (q1 > 18'(EDGE_MAX)) ? EDGE_MAX : q1[EDGE_W-1:0];
  end

  assign result_valid_o = v_r_q;
  assign zone_value_o   = zone_q;
  assign edge_blend_o   = edge_q;

  // ------------------------------------------------------------- checks
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx == dvy)
    else $error("coordinate dividers out of step");

  a_sel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[2] |-> best_q[2] <= sec_q[2])
    else $error("F1 above F2 after selection");

  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv1 && rv2) |-> root2 >= root1)
    else $error("sqrt F2 below sqrt F1");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> edge_blend_o <= EDGE_MAX)
    else $error("edge blend above one");

endmodule
`default_nettype wire
